// ===== hw/rtl/bmp_hv_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_hv_pkg
// Shared types, field layout and status codes of the BMP header validator.
// ----------------------------------------------------------------------------
package bmp_hv_pkg;

  localparam int NumFields = 16;
  localparam int CfgAddrW  = 1;
  localparam int CfgDataW  = 16;

  localparam logic [5:0] LAST_POS = 6'd53;

  localparam logic [5:0] FIELD_FIRST [NumFields] = '{
    6'd0, 6'd2, 6'd6, 6'd8, 6'd10, 6'd14, 6'd18, 6'd22,
    6'd26, 6'd28, 6'd30, 6'd34, 6'd38, 6'd42, 6'd46, 6'd50
  };
  localparam logic [5:0] FIELD_LAST [NumFields] = '{
    6'd1, 6'd5, 6'd7, 6'd9, 6'd13, 6'd17, 6'd21, 6'd25,
    6'd27, 6'd29, 6'd33, 6'd37, 6'd41, 6'd45, 6'd49, 6'd53
  };

  // field index
  localparam logic [3:0] FLD_SIG     = 4'd0;
  localparam logic [3:0] FLD_FSIZE   = 4'd1;
  localparam logic [3:0] FLD_RES1    = 4'd2;
  localparam logic [3:0] FLD_RES2    = 4'd3;
  localparam logic [3:0] FLD_OFFSET  = 4'd4;
  localparam logic [3:0] FLD_HDRSIZE = 4'd5;
  localparam logic [3:0] FLD_WIDTH   = 4'd6;
  localparam logic [3:0] FLD_HEIGHT  = 4'd7;
  localparam logic [3:0] FLD_PLANES  = 4'd8;
  localparam logic [3:0] FLD_BITS    = 4'd9;
  localparam logic [3:0] FLD_COMPR   = 4'd10;
  localparam logic [3:0] FLD_IMGSIZE = 4'd11;
  localparam logic [3:0] FLD_XRES    = 4'd12;
  localparam logic [3:0] FLD_YRES    = 4'd13;
  localparam logic [3:0] FLD_COLOURS = 4'd14;
  localparam logic [3:0] FLD_IMPORT  = 4'd15;

  // status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_ID    = 4'd1;
  localparam logic [3:0] ST_RESERVED  = 4'd2;
  localparam logic [3:0] ST_OFFSET    = 4'd3;
  localparam logic [3:0] ST_HDR_SIZE  = 4'd4;
  localparam logic [3:0] ST_WIDTH     = 4'd5;
  localparam logic [3:0] ST_HEIGHT    = 4'd6;
  localparam logic [3:0] ST_PLANES    = 4'd7;
  localparam logic [3:0] ST_BITS      = 4'd8;
  localparam logic [3:0] ST_COMPR     = 4'd9;
  localparam logic [3:0] ST_IMGSIZE   = 4'd10;
  localparam logic [3:0] ST_XRES      = 4'd11;
  localparam logic [3:0] ST_YRES      = 4'd12;
  localparam logic [3:0] ST_COLOURS   = 4'd13;
  localparam logic [3:0] ST_IMPORTANT = 4'd14;
  localparam logic [3:0] ST_READ      = 4'd15;

  // configuration register addresses
  localparam logic [CfgAddrW-1:0] CFG_MAX_WIDTH  = 1'd0;
  localparam logic [CfgAddrW-1:0] CFG_MAX_HEIGHT = 1'd1;

  localparam logic [CfgDataW-1:0] MAX_DIM_RESET = 16'd4096;

  localparam logic [31:0] SIGNATURE = 32'h0000_4d42;
  localparam logic [31:0] OFFSET_V3 = 32'd54;
  localparam logic [31:0] OFFSET_V4 = 32'd122;
  localparam logic [31:0] OFFSET_V5 = 32'd138;
  localparam logic [31:0] HDR_V3    = 32'd40;
  localparam logic [31:0] HDR_V4    = 32'd108;
  localparam logic [31:0] HDR_V5    = 32'd124;
  localparam logic [31:0] BPP_24    = 32'd24;
  localparam logic [31:0] BPP_32    = 32'd32;

  typedef struct packed {
    logic [3:0] idx;
    logic [1:0] off;
    logic       is_first;
    logic       is_last;
  } field_loc_t;

  // completed field or end of file, passed from front to back
  typedef struct packed {
    logic        new_file;
    logic        eof;
    logic [3:0]  idx;
    logic [31:0] value;
  } fld_evt_t;

  function automatic field_loc_t locate_field(input logic [5:0] pos);
    field_loc_t loc;
    loc = '0;
    for (int i = 0; i < NumFields; i++) begin
      if (pos >= FIELD_FIRST[i]) begin
        loc.idx = 4'(i);
      end
    end
    loc.off      = 2'(pos - FIELD_FIRST[loc.idx]);
    loc.is_first = (pos == FIELD_FIRST[loc.idx]);
    loc.is_last  = (pos == FIELD_LAST[loc.idx]);
    return loc;
  endfunction

endpackage

// ===== hw/rtl/bmp_hv_if.sv =====
// ----------------------------------------------------------------------------
// bmp_hv_if
// Valid/ready channels of the BMP header validator.
// ----------------------------------------------------------------------------
interface bmp_hv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       end_of_file;

  modport source (output valid, data_byte, start_of_file, end_of_file, input ready);
  modport sink   (input valid, data_byte, start_of_file, end_of_file, output ready);
endinterface

interface bmp_hv_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] bad_value;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        flipped;
  logic [5:0]  bits_per_pixel;
  logic [7:0]  data_offset;
  logic [31:0] file_size;

  modport source (output valid, status, bad_value, image_width, image_height, flipped,
                  bits_per_pixel, data_offset, file_size, input ready);
  modport sink   (input valid, status, bad_value, image_width, image_height, flipped,
                  bits_per_pixel, data_offset, file_size, output ready);
endinterface

interface bmp_hv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bmp_hv_pkg::CfgAddrW-1:0]   addr;
  logic [bmp_hv_pkg::CfgDataW-1:0]   data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/bmp_hv_front.sv =====
// ----------------------------------------------------------------------------
// bmp_hv_front
// Byte intake: tracks the header position, assembles little-endian fields
// and pushes one event per completed field or end of file.
// ----------------------------------------------------------------------------
module bmp_hv_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bmp_hv_in_if.sink            in_i,
  input  logic                 q_ready_i,
  output logic                 q_valid_o,
  output bmp_hv_pkg::fld_evt_t q_data_o
);

  logic [5:0]             pos_q, pos_d;
  logic [31:0]            asm_q, asm_d;
  logic                   active_q, active_d;
  logic                   pend_new_q, pend_new_d;
  logic                   take;
  logic                   eff_active;
  logic [5:0]             eff_pos;
  logic                   eff_new;
  bmp_hv_pkg::field_loc_t loc;
  logic [31:0]            merged;

  assign in_i.ready = q_ready_i;
  assign take       = in_i.valid && in_i.ready;

  assign eff_active = in_i.start_of_file || active_q;
  assign eff_pos    = in_i.start_of_file ? 6'd0 : pos_q;
  assign eff_new    = in_i.start_of_file || pend_new_q;
  assign loc        = bmp_hv_pkg::locate_field(eff_pos);
  assign merged     = (loc.is_first ? 32'd0 : asm_q) |
                      (32'(in_i.data_byte) << {loc.off, 3'b000});

  always_comb begin
    pos_d      = pos_q;
    asm_d      = asm_q;
    active_d   = active_q;
    pend_new_d = pend_new_q;
    q_valid_o  = 1'b0;
    q_data_o   = '0;
    if (take && eff_active) begin
      active_d   = 1'b1;
      pend_new_d = eff_new;
      if (in_i.end_of_file) begin
        q_valid_o         = 1'b1;
        q_data_o.new_file = eff_new;
        q_data_o.eof      = 1'b1;
        active_d          = 1'b0;
        pend_new_d        = 1'b0;
      end else begin
        asm_d = merged;
        pos_d = eff_pos + 6'd1;
        if (loc.is_last) begin
          q_valid_o         = 1'b1;
          q_data_o.new_file = eff_new;
          q_data_o.idx      = loc.idx;
          q_data_o.value    = merged;
          pend_new_d        = 1'b0;
          if (eff_pos == bmp_hv_pkg::LAST_POS) begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      active_q   <= 1'b0;
      pend_new_q <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      active_q   <= active_d;
      pend_new_q <= pend_new_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

endmodule

// ===== hw/rtl/bmp_hv_queue.sv =====
// ----------------------------------------------------------------------------
// bmp_hv_queue
// Small FIFO of field events between intake and checker.
// ----------------------------------------------------------------------------
module bmp_hv_queue #(
  parameter int Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bmp_hv_pkg::fld_evt_t push_data_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output bmp_hv_pkg::fld_evt_t pop_data_o,
  input  logic                 pop_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  bmp_hv_pkg::fld_evt_t mem_q [Depth];
  logic [PtrW-1:0]      wptr_q, rptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/bmp_hv_back.sv =====
// ----------------------------------------------------------------------------
// bmp_hv_back
// Field checker: validates each completed field, keeps the geometry and
// drives the registered result.
// ----------------------------------------------------------------------------
module bmp_hv_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              ev_valid_i,
  input  bmp_hv_pkg::fld_evt_t              ev_i,
  output logic                              ev_pop_o,
  input  logic [bmp_hv_pkg::CfgDataW-1:0]   max_width_i,
  input  logic [bmp_hv_pkg::CfgDataW-1:0]   max_height_i,
  bmp_hv_res_if.source                      res_o
);

  logic        out_valid_q, out_valid_d;
  logic        dead_q, dead_d;
  logic [3:0]  status_q, status_d;
  logic [31:0] bad_q, bad_d;
  logic [15:0] owidth_q, owidth_d, oheight_q, oheight_d;
  logic        oflip_q, oflip_d;
  logic [5:0]  obits_q, obits_d;
  logic [7:0]  ooff_q, ooff_d;
  logic [31:0] ofsize_q, ofsize_d;

  logic [31:0] k_fsize_q;
  logic [7:0]  k_off_q;
  logic [15:0] k_width_q, k_height_q;
  logic        k_flip_q;
  logic [5:0]  k_bits_q;

  logic [31:0] v;
  logic        neg;
  logic [31:0] mag;
  logic [3:0]  chk;
  logic        live;
  logic        pass;

  assign ev_pop_o = ev_valid_i && (!out_valid_q || res_o.ready);
  assign live     = ev_pop_o && (ev_i.new_file || !dead_q);
  assign v        = ev_i.value;
  assign neg      = v[31];
  assign mag      = neg ? (32'd0 - v) : v;
  assign pass     = live && !ev_i.eof && (chk == bmp_hv_pkg::ST_OK);

  always_comb begin
    chk = bmp_hv_pkg::ST_OK;
    unique case (ev_i.idx)
      bmp_hv_pkg::FLD_SIG:
        if (v != bmp_hv_pkg::SIGNATURE) chk = bmp_hv_pkg::ST_BAD_ID;
      bmp_hv_pkg::FLD_FSIZE: chk = bmp_hv_pkg::ST_OK;
      bmp_hv_pkg::FLD_RES1, bmp_hv_pkg::FLD_RES2:
        if (v != 32'd0) chk = bmp_hv_pkg::ST_RESERVED;
      bmp_hv_pkg::FLD_OFFSET:
        if (v != bmp_hv_pkg::OFFSET_V3 && v != bmp_hv_pkg::OFFSET_V4 &&
            v != bmp_hv_pkg::OFFSET_V5) chk = bmp_hv_pkg::ST_OFFSET;
      bmp_hv_pkg::FLD_HDRSIZE:
        if (v != bmp_hv_pkg::HDR_V3 && v != bmp_hv_pkg::HDR_V4 &&
            v != bmp_hv_pkg::HDR_V5) chk = bmp_hv_pkg::ST_HDR_SIZE;
      bmp_hv_pkg::FLD_WIDTH:
        if (v == 32'd0 || neg || v > {16'd0, max_width_i}) chk = bmp_hv_pkg::ST_WIDTH;
      bmp_hv_pkg::FLD_HEIGHT:
        if (mag == 32'd0 || mag > {16'd0, max_height_i}) chk = bmp_hv_pkg::ST_HEIGHT;
      bmp_hv_pkg::FLD_PLANES:
        if (v != 32'd1) chk = bmp_hv_pkg::ST_PLANES;
      bmp_hv_pkg::FLD_BITS:
        if (v != bmp_hv_pkg::BPP_24 && v != bmp_hv_pkg::BPP_32) chk = bmp_hv_pkg::ST_BITS;
      bmp_hv_pkg::FLD_COMPR:
        if (v != 32'd0) chk = bmp_hv_pkg::ST_COMPR;
      bmp_hv_pkg::FLD_IMGSIZE:
        if (neg) chk = bmp_hv_pkg::ST_IMGSIZE;
      bmp_hv_pkg::FLD_XRES:
        if (neg) chk = bmp_hv_pkg::ST_XRES;
      bmp_hv_pkg::FLD_YRES:
        if (neg) chk = bmp_hv_pkg::ST_YRES;
      bmp_hv_pkg::FLD_COLOURS:
        if (v != 32'd0) chk = bmp_hv_pkg::ST_COLOURS;
      bmp_hv_pkg::FLD_IMPORT:
        if (v != 32'd0) chk = bmp_hv_pkg::ST_IMPORTANT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !res_o.ready;
    dead_d      = ev_pop_o && ev_i.new_file ? 1'b0 : dead_q;
    status_d    = status_q;
    bad_d       = bad_q;
    owidth_d    = owidth_q;
    oheight_d   = oheight_q;
    oflip_d     = oflip_q;
    obits_d     = obits_q;
    ooff_d      = ooff_q;
    ofsize_d    = ofsize_q;
    if (live && (ev_i.eof || chk != bmp_hv_pkg::ST_OK ||
                 ev_i.idx == bmp_hv_pkg::FLD_IMPORT)) begin
      out_valid_d = 1'b1;
      dead_d      = 1'b1;
      status_d    = ev_i.eof ? bmp_hv_pkg::ST_READ : chk;
      bad_d       = (ev_i.eof || chk == bmp_hv_pkg::ST_OK) ? 32'd0 : v;
      owidth_d    = pass ? k_width_q  : 16'd0;
      oheight_d   = pass ? k_height_q : 16'd0;
      oflip_d     = pass ? k_flip_q   : 1'b0;
      obits_d     = pass ? k_bits_q   : 6'd0;
      ooff_d      = pass ? k_off_q    : 8'd0;
      ofsize_d    = pass ? k_fsize_q  : 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      dead_q      <= 1'b1;
    end else begin
      out_valid_q <= out_valid_d;
      dead_q      <= dead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    bad_q     <= bad_d;
    owidth_q  <= owidth_d;
    oheight_q <= oheight_d;
    oflip_q   <= oflip_d;
    obits_q   <= obits_d;
    ooff_q    <= ooff_d;
    ofsize_q  <= ofsize_d;
    if (pass) begin
      unique case (ev_i.idx)
        bmp_hv_pkg::FLD_FSIZE:  k_fsize_q <= v;
        bmp_hv_pkg::FLD_OFFSET: k_off_q   <= v[7:0];
        bmp_hv_pkg::FLD_WIDTH:  k_width_q <= v[15:0];
        bmp_hv_pkg::FLD_HEIGHT: begin
          k_height_q <= mag[15:0];
          k_flip_q   <= neg;
        end
        bmp_hv_pkg::FLD_BITS:   k_bits_q  <= v[5:0];
        default: ;
      endcase
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.status         = status_q;
  assign res_o.bad_value      = bad_q;
  assign res_o.image_width    = owidth_q;
  assign res_o.image_height   = oheight_q;
  assign res_o.flipped        = oflip_q;
  assign res_o.bits_per_pixel = obits_q;
  assign res_o.data_offset    = ooff_q;
  assign res_o.file_size      = ofsize_q;

endmodule

// ===== hw/rtl/bmp_header_validator.sv =====
// ----------------------------------------------------------------------------
// bmp_header_validator
// Parses and checks the 54-byte BMP file and info header, one byte a cycle.
//
//   channel  dir  payload                                        transaction
//   in_i     in   data_byte, start_of_file, end_of_file          valid & ready
//   cfg_i    in   addr (0 max_width, 1 max_height), data         valid & ready
//   res_o    out  status, bad_value, geometry, data_offset, size valid & ready
//
// One byte per cycle while in_i.ready is high. The byte that ends the parse
// pushes its field event into the queue; the checker pops it and loads the
// output register that drives the result. After reset both limits are 4096
// and the block ignores bytes until a start_of_file. A stalled result holds
// the output register and the checker stops popping; once the event queue
// (QueueDepth entries) fills, in_i.ready drops.
// ----------------------------------------------------------------------------
module bmp_header_validator #(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bmp_hv_cfg_if.sink    cfg_i,
  bmp_hv_in_if.sink     in_i,
  bmp_hv_res_if.source  res_o
);

  logic [bmp_hv_pkg::CfgDataW-1:0] max_width_q, max_height_q;
  logic                            push, push_ready, ev_valid, ev_pop;
  bmp_hv_pkg::fld_evt_t            push_data, ev;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q  <= bmp_hv_pkg::MAX_DIM_RESET;
      max_height_q <= bmp_hv_pkg::MAX_DIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        bmp_hv_pkg::CFG_MAX_WIDTH:  max_width_q  <= cfg_i.data;
        bmp_hv_pkg::CFG_MAX_HEIGHT: max_height_q <= cfg_i.data;
      endcase
    end
  end

  bmp_hv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (push_ready),
    .q_valid_o (push),
    .q_data_o  (push_data)
  );

  bmp_hv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (ev_valid),
    .pop_data_o   (ev),
    .pop_i        (ev_pop)
  );

  bmp_hv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_valid_i   (ev_valid),
    .ev_i         (ev),
    .ev_pop_o     (ev_pop),
    .max_width_i  (max_width_q),
    .max_height_i (max_height_q),
    .res_o        (res_o)
  );

endmodule

// ===== hw/rtl/bmp_hv_checker.sv =====
// ----------------------------------------------------------------------------
// bmp_hv_checker
// Port-level checks on the result channel of the BMP header validator.
// ----------------------------------------------------------------------------
module bmp_hv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [3:0]  status_i,
  input logic [31:0] bad_value_i,
  input logic [15:0] image_width_i,
  input logic [15:0] image_height_i,
  input logic        flipped_i,
  input logic [5:0]  bits_per_pixel_i,
  input logic [7:0]  data_offset_i,
  input logic [31:0] file_size_i
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(status_i) && $stable(bad_value_i))
    else $error("result changed while stalled");

  a_ok_geometry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == bmp_hv_pkg::ST_OK |->
      (bits_per_pixel_i == 6'd24 || bits_per_pixel_i == 6'd32) &&
      (data_offset_i == 8'd54 || data_offset_i == 8'd122 || data_offset_i == 8'd138) &&
      image_width_i != 16'd0 && image_height_i != 16'd0 && bad_value_i == 32'd0)
    else $error("ok result with invalid geometry");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i != bmp_hv_pkg::ST_OK |->
      image_width_i == 16'd0 && image_height_i == 16'd0 && !flipped_i &&
      bits_per_pixel_i == 6'd0 && data_offset_i == 8'd0 && file_size_i == 32'd0)
    else $error("failed result carries geometry");

  a_read_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == bmp_hv_pkg::ST_READ |-> bad_value_i == 32'd0)
    else $error("read error with nonzero value");

endmodule

bind bmp_header_validator bmp_hv_checker u_bmp_hv_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .status_i         (res_o.status),
  .bad_value_i      (res_o.bad_value),
  .image_width_i    (res_o.image_width),
  .image_height_i   (res_o.image_height),
  .flipped_i        (res_o.flipped),
  .bits_per_pixel_i (res_o.bits_per_pixel),
  .data_offset_i    (res_o.data_offset),
  .file_size_i      (res_o.file_size)
);
